### design/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PLR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PLR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/plr_pkg.sv
// Package: widths, codes and controller/datapath interface types of the line rasterizer.
`timescale 1ns / 1ps
package plr_pkg;
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int PAT_BITS   = 32;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_STEP   = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_len;
      logic div_last;
      logic at_limit;
   } dp_status_type;
endpackage

### design/patterned_line_rasterizer_core.sv
// Top level of the patterned line rasterizer: controller plus datapath.
`timescale 1ns / 1ps
// A start request (op 0) loads two endpoints and a dash pattern and always gives no result.
// Setup then runs a radix-2 divider for the 1.16 minor increment, one quotient bit per
// clock: req_stall stays high after a start until the divide ends (not at all for a
// zero-length line). Each step request (op 1) then yields one pixel per clock unless
// rsp_stall holds the output register, endpoints included, last_pixel on the final one;
// idle step requests are taken and dropped. A start abandons any line in progress.
module patterned_line_rasterizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_x_start,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_y_start,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_x_end,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_y_end,
   input  logic        [plr_pkg::PAT_BITS-1:0]   req_dash_pattern,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic                                  rsp_draw,
   output logic                                  rsp_last_pixel
);
   import plr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   plr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .rsp_stall (rsp_stall),
      .status    (status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   plr_datapath u_datapath (
      .clock            (clock),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_dash_pattern (req_dash_pattern),
      .cmd              (cmd),
      .status           (status),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_draw         (rsp_draw),
      .rsp_last_pixel   (rsp_last_pixel)
   );
endmodule

### design/plr_ctrl.sv
// Controller: line setup, division sequencing and output handshake.
`timescale 1ns / 1ps
module plr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   input  logic                  rsp_stall,
   input  plr_pkg::dp_status_type status,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output plr_pkg::dp_cmd_type   cmd
);
   import plr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_start;

   assign req_stall = (state_ff == ST_DIVIDE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_start  = (req_op == OP_START);

   assign cmd.load     = accept && is_start;
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.emit     = accept && !is_start && (state_ff == ST_STEP);

   always_comb begin
      state_in = state_ff;
      if (cmd.load) begin
         state_in = status.zero_len ? ST_STEP : ST_DIVIDE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            ST_DIVIDE: begin
               if (status.div_last) state_in = ST_STEP;
            end
            ST_STEP: begin
               if (cmd.emit && status.at_limit) state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.emit) rsp_valid_in = 1'b1;
      else          rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### design/plr_datapath.sv
// Datapath: endpoint setup, radix-2 increment divider, major/minor stepping, output register.
`timescale 1ns / 1ps
module plr_datapath (
   input  logic                                  clock,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_x_start,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_y_start,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_x_end,
   input  logic signed [plr_pkg::COORD_BITS-1:0] req_y_end,
   input  logic        [plr_pkg::PAT_BITS-1:0]   req_dash_pattern,
   input  plr_pkg::dp_cmd_type                   cmd,
   output plr_pkg::dp_status_type                status,
   output logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic                                  rsp_draw,
   output logic                                  rsp_last_pixel
);
   import plr_pkg::*;

   // setup
   logic signed [COORD_BITS:0]   dx, dy, long_d, short_d;
   logic        [COORD_BITS:0]   adx_w, ady_w;
   logic        [COORD_BITS-1:0] adx, ady, long_abs, short_abs;
   logic                         major_y;
   logic signed [COORD_BITS-1:0] minor_start;

   // line state
   logic                         major_is_y_ff;
   logic                         stepping_up_ff;
   logic                         acc_add_ff;
   logic        [COORD_BITS-1:0] pos_ff, pos_in;
   logic        [COORD_BITS-1:0] limit_ff;
   logic        [ACC_BITS-1:0]   acc_ff, acc_in;
   logic        [PAT_BITS-1:0]   pat_ff, pat_in;

   // divider
   logic        [COORD_BITS:0]   rem_ff, rem_in, rem_sel, rem_diff;
   logic        [COORD_BITS-1:0] div_ff;
   logic        [QUO_BITS-1:0]   quo_ff, quo_in;
   logic        [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                         quo_bit;

   // output register
   logic        [COORD_BITS-1:0] px_ff, py_ff;
   logic                         draw_ff, last_ff;
   logic        [COORD_BITS-1:0] minor_out;

   assign dx = {req_x_end[COORD_BITS-1], req_x_end} - {req_x_start[COORD_BITS-1], req_x_start};
   assign dy = {req_y_end[COORD_BITS-1], req_y_end} - {req_y_start[COORD_BITS-1], req_y_start};
   assign adx_w = dx[COORD_BITS] ? -dx : dx;
   assign ady_w = dy[COORD_BITS] ? -dy : dy;
   assign adx   = adx_w[COORD_BITS-1:0];
   assign ady   = ady_w[COORD_BITS-1:0];
   assign major_y     = ady > adx;
   assign long_d      = major_y ? dy : dx;
   assign short_d     = major_y ? dx : dy;
   assign long_abs    = major_y ? ady : adx;
   assign short_abs   = major_y ? adx : ady;
   assign minor_start = major_y ? req_x_start : req_y_start;

   assign status.zero_len = (long_abs == '0);
   assign status.div_last = (cnt_ff == CNT_BITS'(FRAC_BITS));
   assign status.at_limit = (pos_ff == limit_ff);

   // one quotient bit per cycle, MSB first
   assign rem_diff = rem_ff - {1'b0, div_ff};
   assign quo_bit  = (rem_ff >= {1'b0, div_ff});
   assign rem_sel  = quo_bit ? rem_diff : rem_ff;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         rem_in = {1'b0, short_abs};
         quo_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = {rem_sel[COORD_BITS-1:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], quo_bit};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      acc_in = acc_ff;
      pat_in = pat_ff;
      if (cmd.load) begin
         pos_in = major_y ? req_y_start : req_x_start;
         acc_in = {minor_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
         pat_in = req_dash_pattern;
      end else if (cmd.emit) begin
         pos_in = stepping_up_ff ? pos_ff + 1'b1 : pos_ff - 1'b1;
         acc_in = acc_add_ff ? acc_ff + ACC_BITS'(quo_ff) : acc_ff - ACC_BITS'(quo_ff);
         pat_in = {pat_ff[0], pat_ff[PAT_BITS-1:1]};
      end
   end

   assign minor_out = acc_ff[ACC_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      acc_ff <= acc_in;
      pat_ff <= pat_in;
      if (cmd.load) begin
         div_ff         <= long_abs;
         limit_ff       <= major_y ? req_y_end : req_x_end;
         major_is_y_ff  <= major_y;
         stepping_up_ff <= !long_d[COORD_BITS] && (long_d != '0);
         acc_add_ff     <= (!long_d[COORD_BITS] && (long_d != '0))
                           ^ (short_d[COORD_BITS] ^ long_d[COORD_BITS]);
      end
      if (cmd.emit) begin
         px_ff   <= major_is_y_ff ? minor_out : pos_ff;
         py_ff   <= major_is_y_ff ? pos_ff : minor_out;
         draw_ff <= pat_ff[0];
         last_ff <= status.at_limit;
      end
   end

   assign rsp_pixel_x    = px_ff;
   assign rsp_pixel_y    = py_ff;
   assign rsp_draw       = draw_ff;
   assign rsp_last_pixel = last_ff;
endmodule

### design/plr_checker.sv
// Port-level checker for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_op,
   input logic signed [plr_pkg::COORD_BITS-1:0] req_x_start,
   input logic signed [plr_pkg::COORD_BITS-1:0] req_y_start,
   input logic signed [plr_pkg::COORD_BITS-1:0] req_x_end,
   input logic signed [plr_pkg::COORD_BITS-1:0] req_y_end,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [plr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   input logic                                  rsp_draw,
   input logic                                  rsp_last_pixel
);
   import plr_pkg::*;

   logic                      start_acc;
   logic                      zero_len;
   logic                      rsp_hold;
   logic [2*COORD_BITS+1:0]   rsp_bus;

   assign start_acc = req_valid && !req_stall && (req_op == OP_START);
   assign zero_len  = (req_x_end == req_x_start) && (req_y_end == req_y_start);
   assign rsp_hold  = rsp_valid && rsp_stall;
   assign rsp_bus   = {rsp_pixel_x, rsp_pixel_y, rsp_draw, rsp_last_pixel};

   `PLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, rsp_valid && $stable(rsp_bus), "stalled response changed")
   `PLR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")
   `PLR_ASSERT_NEXT(a_start_no_rsp, clock, reset, start_acc && !rsp_hold, !rsp_valid, "start gave a response")
   `PLR_ASSERT_NEXT(a_start_divides, clock, reset, start_acc && !zero_len, req_stall, "no divide stall after start")
endmodule

bind patterned_line_rasterizer_core plr_checker u_plr_checker (.*);

### verif/patterned_line_rasterizer_core_tb.sv
// Testbench for the patterned line rasterizer: directed and random line requests checked against a predictor.
`timescale 1ns / 1ps
module patterned_line_rasterizer_core_tb;
   import plr_pkg::*;

   localparam int ITEM_BUDGET = 850;
   localparam int IDLE_LIMIT  = 5000;
   localparam int MIN_COORD   = -(1 << (COORD_BITS - 1));
   localparam int MAX_COORD   = (1 << (COORD_BITS - 1)) - 1;

   typedef struct {
      op_type                 op;
      logic [COORD_BITS-1:0]  x_start;
      logic [COORD_BITS-1:0]  y_start;
      logic [COORD_BITS-1:0]  x_end;
      logic [COORD_BITS-1:0]  y_end;
      logic [PAT_BITS-1:0]    dash_pattern;
   } line_request_type;

   typedef struct {
      logic [COORD_BITS-1:0]  pixel_x;
      logic [COORD_BITS-1:0]  pixel_y;
      logic                   draw;
      logic                   last_pixel;
   } pixel_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_op;
   logic signed [COORD_BITS-1:0]  req_x_start;
   logic signed [COORD_BITS-1:0]  req_y_start;
   logic signed [COORD_BITS-1:0]  req_x_end;
   logic signed [COORD_BITS-1:0]  req_y_end;
   logic        [PAT_BITS-1:0]    req_dash_pattern;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [COORD_BITS-1:0]  rsp_pixel_x;
   logic signed [COORD_BITS-1:0]  rsp_pixel_y;
   logic                          rsp_draw;
   logic                          rsp_last_pixel;

   patterned_line_rasterizer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_dash_pattern (req_dash_pattern),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_draw         (rsp_draw),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   always #4 clock = ~clock;

   line_request_type pending_requests[$];
   pixel_type        expected_pixels[$];

   // predictor state
   logic                  line_active;
   logic                  line_y_major;
   logic                  line_up;
   int                    line_pos;
   int                    line_limit;
   logic [31:0]           line_acc;
   logic [31:0]           line_inc;
   logic [PAT_BITS-1:0]   line_pattern;

   // stimulus bookkeeping
   int    items_made;
   int    pixels_left;

   int    mismatches;
   int    idle_cycles;
   int    cycle_count;
   int    gap_left;
   int    stall_left;
   logic  req_taken;

   function automatic int clamp_coord(int v);
      if (v < MIN_COORD) return MIN_COORD;
      if (v > MAX_COORD) return MAX_COORD;
      return v;
   endfunction

   function automatic int rand_coord();
      logic signed [COORD_BITS-1:0] v;
      v = COORD_BITS'($urandom);
      return int'(v);
   endfunction

   function automatic int rand_offset(int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic int edge_coord();
      if ($urandom_range(0, 1) == 0) return MIN_COORD + int'($urandom_range(0, 6));
      return MAX_COORD - int'($urandom_range(0, 6));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic calm_phase();
      return ((cycle_count / 512) % 4) == 0;
   endfunction

   task automatic add_line(int xs, int ys, int xe, int ye, logic [PAT_BITS-1:0] pat);
      line_request_type rq;
      int dx, dy;
      rq.op = OP_START;
      rq.x_start = COORD_BITS'(xs);
      rq.y_start = COORD_BITS'(ys);
      rq.x_end = COORD_BITS'(xe);
      rq.y_end = COORD_BITS'(ye);
      rq.dash_pattern = pat;
      pending_requests = {pending_requests, rq};
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      pixels_left = ((dx > dy) ? dx : dy) + 1;
      items_made++;
   endtask

   task automatic add_steps(int n);
      line_request_type rq;
      for (int i = 0; i < n; i++) begin
         rq.op = OP_STEP;
         rq.x_start = COORD_BITS'($urandom);
         rq.y_start = COORD_BITS'($urandom);
         rq.x_end = COORD_BITS'($urandom);
         rq.y_end = COORD_BITS'($urandom);
         rq.dash_pattern = $urandom;
         pending_requests = {pending_requests, rq};
         if (pixels_left > 0) pixels_left--;
         items_made++;
      end
   endtask

   function automatic void predict_request(logic op, int xs, int ys, int xe, int ye,
                                           logic [PAT_BITS-1:0] pat);
      int                   d_major, d_minor, major_start, minor_start, tmp;
      logic signed [31:0]   acc_signed;
      logic signed [31:0]   minor_full;
      logic                 flag;
      pixel_type            px;
      if (op == OP_START) begin
         d_major = xe - xs;
         d_minor = ye - ys;
         major_start = xs;
         minor_start = ys;
         line_y_major = 1'b0;
         if ((d_minor < 0 ? -d_minor : d_minor) > (d_major < 0 ? -d_major : d_major)) begin
            tmp = d_minor;
            d_minor = d_major;
            d_major = tmp;
            line_y_major = 1'b1;
            major_start = ys;
            minor_start = xs;
         end
         line_inc = (d_major != 0) ? (d_minor * (1 << FRAC_BITS)) / d_major : 0;
         line_acc = (minor_start * (1 << FRAC_BITS)) + (1 << (FRAC_BITS - 1));
         line_up = d_major > 0;
         line_pos = major_start;
         line_limit = major_start + d_major;
         line_pattern = pat;
         line_active = 1'b1;
      end else if (line_active) begin
         acc_signed = line_acc;
         minor_full = acc_signed >>> FRAC_BITS;
         flag = line_pattern[0];
         px.pixel_x = line_y_major ? minor_full[COORD_BITS-1:0] : line_pos[COORD_BITS-1:0];
         px.pixel_y = line_y_major ? line_pos[COORD_BITS-1:0] : minor_full[COORD_BITS-1:0];
         px.draw = flag;
         px.last_pixel = (line_pos == line_limit);
         expected_pixels = {expected_pixels, px};
         line_pattern = {flag, line_pattern[PAT_BITS-1:1]};
         if (px.last_pixel) begin
            line_active = 1'b0;
         end else if (line_up) begin
            line_pos++;
            line_acc = line_acc + line_inc;
         end else begin
            line_pos--;
            line_acc = line_acc - line_inc;
         end
      end
   endfunction

   // request driver: observe the handshake at the rising edge, drive at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_request(req_op, int'(req_x_start), int'(req_y_start), int'(req_x_end),
                         int'(req_y_end), req_dash_pattern);
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      line_request_type rq;
      if (!reset) begin
         cycle_count++;
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_op <= rq.op;
               req_x_start <= rq.x_start;
               req_y_start <= rq.y_start;
               req_x_end <= rq.x_end;
               req_y_end <= rq.y_end;
               req_dash_pattern <= rq.dash_pattern;
               req_valid <= 1'b1;
               gap_left = calm_phase() ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left == 0 && !calm_phase() && $urandom_range(0, 1) == 0)
            stall_left = pick_gap();
         rsp_stall <= (stall_left != 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // pixel monitor and watchdog
   always @(posedge clock) begin
      pixel_type exp_px;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected pixel x=%0d y=%0d draw=%0b last=%0b",
                           rsp_pixel_x, rsp_pixel_y, rsp_draw, rsp_last_pixel);
            end else begin
               exp_px = expected_pixels.pop_front();
               if (rsp_pixel_x !== exp_px.pixel_x || rsp_pixel_y !== exp_px.pixel_y ||
                   rsp_draw !== exp_px.draw || rsp_last_pixel !== exp_px.last_pixel) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: pixel exp x=%0d y=%0d draw=%0b last=%0b, ",
                               "got x=%0d y=%0d draw=%0b last=%0b"},
                              $signed(exp_px.pixel_x), $signed(exp_px.pixel_y), exp_px.draw,
                              exp_px.last_pixel, rsp_pixel_x, rsp_pixel_y, rsp_draw,
                              rsp_last_pixel);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no request or pixel moved for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int r, xs, ys;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_START;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end = '0;
      req_y_end = '0;
      req_dash_pattern = '0;
      rsp_stall = 1'b0;
      line_active = 1'b0;
      line_y_major = 1'b0;
      line_up = 1'b0;
      line_pos = 0;
      line_limit = 0;
      line_acc = '0;
      line_inc = '0;
      line_pattern = '1;
      items_made = 0;
      pixels_left = 0;
      mismatches = 0;
      idle_cycles = 0;
      cycle_count = 0;
      gap_left = 0;
      stall_left = 0;
      req_taken = 1'b0;

      // directed lines
      add_steps(1);                                               // step with no line
      add_line(MAX_COORD, MIN_COORD, MAX_COORD, MIN_COORD, 32'h0); // single point
      add_steps(2);
      add_line(MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD, 32'hFFFF_FFFF); // full tie
      add_steps(3);
      add_line(0, MIN_COORD, 5, MAX_COORD, 32'h8000_0001);        // steep, abandoned
      add_steps(4);
      add_line(3, 3, 1, -2, 32'hAAAA_AAAA);
      add_steps(6);
      add_line(10, 10, 7, 13, 32'h5555_5555);
      add_steps(4);
      add_line(100, 200, -300, 7, 32'h1234_5678);                 // replaced with no steps
      add_line(MIN_COORD + 2, 5, MIN_COORD, 4, 32'hF0F0_0F0F);
      add_steps(3);
      add_line(MAX_COORD - 2, MAX_COORD - 1, MAX_COORD, MAX_COORD, 32'h0000_0006);
      add_steps(4);

      while (items_made < ITEM_BUDGET) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            xs = rand_coord();
            ys = rand_coord();
            add_line(xs, ys, clamp_coord(xs + rand_offset(12)), clamp_coord(ys + rand_offset(12)),
                     $urandom);
            if ($urandom_range(0, 9) == 0) add_steps($urandom_range(0, pixels_left - 1));
            else if ($urandom_range(0, 4) == 0) add_steps(pixels_left + $urandom_range(1, 3));
            else add_steps(pixels_left);
         end else if (r < 72) begin
            xs = edge_coord();
            ys = edge_coord();
            add_line(xs, ys, clamp_coord(xs + rand_offset(8)), clamp_coord(ys + rand_offset(8)),
                     $urandom);
            add_steps(pixels_left);
         end else if (r < 86) begin
            add_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
            add_steps($urandom_range(1, 24));
         end else if (r < 92) begin
            add_steps($urandom_range(1, 3));
         end else if (r < 97) begin
            xs = rand_coord();
            ys = rand_coord();
            add_line(xs, ys, clamp_coord(xs + rand_offset(100)),
                     clamp_coord(ys + rand_offset(100)), $urandom);
            add_steps(pixels_left);
         end else begin
            add_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_pixels.size() > 0)
            $display("ERROR: %0d expected pixels never arrived", expected_pixels.size());
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

### files.f
+incdir+design
design/plr_pkg.sv
design/plr_ctrl.sv
design/plr_datapath.sv
design/patterned_line_rasterizer_core.sv
design/plr_checker.sv
verif/patterned_line_rasterizer_core_tb.sv
